// File: sv/p2p_pkg.sv
// Shared constants and types for the point-to-pixel projection block.
`default_nettype none
package p2p_pkg;

  localparam int COORD_W   = 24;                // width of each point coordinate
  localparam int CFG_W     = 20;                // width of focal and centre registers
  localparam int OFS_W     = 32;                // width of offset registers
  localparam int PIX_W     = 16;                // width of a pixel coordinate
  localparam int QBITS     = PIX_W + 1;         // quotient bits resolved by the divider
  localparam int PROD_W    = COORD_W + CFG_W + 1;
  localparam int NUM_W     = PROD_W + 1;
  localparam int FRAC_W    = 8;
  localparam int MAG_W     = NUM_W - FRAC_W;
  localparam int ZMAG_W    = COORD_W;
  localparam int REM_W     = ZMAG_W + QBITS;
  localparam int NSTG      = QBITS + 4;         // multiply, sum, range check, steps, output
  localparam int ADDR_W    = 5;

  localparam logic [2:0] REG_FOCAL_X  = 3'd0;
  localparam logic [2:0] REG_FOCAL_Y  = 3'd1;
  localparam logic [2:0] REG_CENTER_X = 3'd2;
  localparam logic [2:0] REG_CENTER_Y = 3'd3;
  localparam logic [2:0] REG_OFFSET_X = 3'd4;
  localparam logic [2:0] REG_OFFSET_Y = 3'd5;

  localparam logic [CFG_W-1:0] FOCAL_X_RST  = CFG_W'(135800);
  localparam logic [CFG_W-1:0] FOCAL_Y_RST  = CFG_W'(135800);
  localparam logic [CFG_W-1:0] CENTER_X_RST = CFG_W'(82048);
  localparam logic [CFG_W-1:0] CENTER_Y_RST = CFG_W'(61568);
  localparam logic [OFS_W-1:0] OFFSET_X_RST = OFS_W'(-9505966);
  localparam logic [OFS_W-1:0] OFFSET_Y_RST = OFS_W'(0);

  // one divider lane: sign of the result, range overflow, partial remainder, quotient
  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [REM_W-1:0] rem;
    logic [QBITS-1:0] quo;
  } div_lane_t;

  // per-item control that rides alongside the divider lanes
  typedef struct packed {
    logic [ZMAG_W-1:0] zmag;
    logic              dz;
  } div_ctl_t;

endpackage
`default_nettype wire

// File: sv/point_to_pixel_projection.sv
// Top level: pipelined pinhole projection with perspective divide and APB registers.
`default_nettype none
// Projects one camera-frame point (x, y, z in signed mm) to pixel (u, v) per clock.
// A new point is taken every cycle when the output side keeps up. Two 20x24
// multipliers per row feed a three-input add, then a restoring divider of 17
// pipeline steps (one quotient bit per stage) sets the depth. Each stage holds on
// a stall only when it and all later stages are full, so bubbles are squeezed out.
// Registers sit at byte addresses 0x00..0x14, pready is always high, and registers
// should be written only while the pipeline is empty.
module point_to_pixel_projection import p2p_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic signed [COORD_W-1:0] in_point_x,
  input  wire logic signed [COORD_W-1:0] in_point_y,
  input  wire logic signed [COORD_W-1:0] in_point_z,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic signed [PIX_W-1:0]   out_pixel_u,
  output      logic signed [PIX_W-1:0]   out_pixel_v,
  output      logic                      out_depth_zero,
  output      logic                      out_clipped,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [ADDR_W-1:0]         paddr,
  input  wire logic [31:0]               pwdata,
  output      logic [31:0]               prdata,
  output      logic                      pready
);

  logic [CFG_W-1:0] focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic [OFS_W-1:0] offset_x_r, offset_y_r;
  logic [2:0]       reg_idx;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= FOCAL_X_RST;
      focal_y_r  <= FOCAL_Y_RST;
      center_x_r <= CENTER_X_RST;
      center_y_r <= CENTER_Y_RST;
      offset_x_r <= OFFSET_X_RST;
      offset_y_r <= OFFSET_Y_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_FOCAL_X:  focal_x_r  <= pwdata[CFG_W-1:0];
        REG_FOCAL_Y:  focal_y_r  <= pwdata[CFG_W-1:0];
        REG_CENTER_X: center_x_r <= pwdata[CFG_W-1:0];
        REG_CENTER_Y: center_y_r <= pwdata[CFG_W-1:0];
        REG_OFFSET_X: offset_x_r <= pwdata;
        REG_OFFSET_Y: offset_y_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FOCAL_X:  prdata = 32'(focal_x_r);
      REG_FOCAL_Y:  prdata = 32'(focal_y_r);
      REG_CENTER_X: prdata = 32'(center_x_r);
      REG_CENTER_Y: prdata = 32'(center_y_r);
      REG_OFFSET_X: prdata = offset_x_r;
      REG_OFFSET_Y: prdata = offset_y_r;
      default:      prdata = 32'd0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int i = NSTG-2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // ---------------- stage 0: products ----------------
  logic signed [PROD_W-1:0]  pfx_r, pcx_r, pfy_r, pcy_r;
  logic signed [COORD_W-1:0] z_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pfx_r <= PROD_W'($signed({1'b0, focal_x_r}) * in_point_x);
      pcx_r <= PROD_W'($signed({1'b0, center_x_r}) * in_point_z);
      pfy_r <= PROD_W'($signed({1'b0, focal_y_r}) * in_point_y);
      pcy_r <= PROD_W'($signed({1'b0, center_y_r}) * in_point_z);
      z_r   <= in_point_z;
    end
  end

  // ---------------- stage 1: numerators, magnitudes, signs ----------------
  logic signed [NUM_W-1:0] nu, nv;
  logic [NUM_W-1:0]        nu_mag, nv_mag;
  logic [ZMAG_W-1:0]       zmag;
  logic [MAG_W-1:0]        mag_u_r, mag_v_r;
  logic                    neg_u_r, neg_v_r;
  div_ctl_t                ctl1_r;

  always_comb begin
    nu     = NUM_W'(pfx_r) + NUM_W'(pcx_r) + NUM_W'($signed(offset_x_r));
    nv     = NUM_W'(pfy_r) + NUM_W'(pcy_r) + NUM_W'($signed(offset_y_r));
    nu_mag = nu[NUM_W-1] ? NUM_W'(-nu) : NUM_W'(nu);
    nv_mag = nv[NUM_W-1] ? NUM_W'(-nv) : NUM_W'(nv);
    zmag   = z_r[COORD_W-1] ? ZMAG_W'(-z_r) : ZMAG_W'(z_r);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      // drop the Q.8 fraction: floor(|n|/256) / |z| has the same integer part
      mag_u_r     <= nu_mag[NUM_W-1:FRAC_W];
      mag_v_r     <= nv_mag[NUM_W-1:FRAC_W];
      neg_u_r     <= nu[NUM_W-1] ^ z_r[COORD_W-1];
      neg_v_r     <= nv[NUM_W-1] ^ z_r[COORD_W-1];
      ctl1_r.zmag <= zmag;
      ctl1_r.dz   <= (z_r == '0);
    end
  end

  // ---------------- stage 2: range check; stages 3..19: one quotient bit each ----------------
  div_lane_t divu_r [0:QBITS];
  div_lane_t divv_r [0:QBITS];
  div_ctl_t  ctl_r  [0:QBITS];

  logic [REM_W-1:0] zlim;
  assign zlim = {ctl1_r.zmag, {QBITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      divu_r[0].neg <= neg_u_r;
      divu_r[0].ovf <= REM_W'(mag_u_r) >= zlim;
      divu_r[0].rem <= REM_W'(mag_u_r);
      divu_r[0].quo <= '0;
      divv_r[0].neg <= neg_v_r;
      divv_r[0].ovf <= REM_W'(mag_v_r) >= zlim;
      divv_r[0].rem <= REM_W'(mag_v_r);
      divv_r[0].quo <= '0;
      ctl_r[0]      <= ctl1_r;
    end
  end

  for (genvar s = 1; s <= QBITS; s++) begin : g_div
    localparam int K = QBITS - s;
    logic [REM_W-1:0] trial;
    div_lane_t        nu_step, nv_step;

    assign trial = REM_W'(ctl_r[s-1].zmag) << K;

    always_comb begin
      nu_step = divu_r[s-1];
      nv_step = divv_r[s-1];
      if (divu_r[s-1].rem >= trial) begin
        nu_step.rem    = divu_r[s-1].rem - trial;
        nu_step.quo[K] = 1'b1;
      end
      if (divv_r[s-1].rem >= trial) begin
        nv_step.rem    = divv_r[s-1].rem - trial;
        nv_step.quo[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[2+s]) begin
        divu_r[s] <= nu_step;
        divv_r[s] <= nv_step;
        ctl_r[s]  <= ctl_r[s-1];
      end
    end
  end

  // ---------------- output stage: sign, saturation, zero depth ----------------
  localparam logic [QBITS-1:0] POS_MAX = QBITS'((1 << (PIX_W-1)) - 1);
  localparam logic [QBITS-1:0] NEG_MAX = QBITS'(1 << (PIX_W-1));

  function automatic logic [PIX_W:0] sat_lane(input div_lane_t d);
    logic [PIX_W-1:0] val;
    logic             clip;
    begin
      clip = 1'b0;
      if (d.neg) begin
        if (d.ovf || d.quo > NEG_MAX) begin
          clip = 1'b1;
          val  = {1'b1, {(PIX_W-1){1'b0}}};
        end else begin
          val = PIX_W'(-d.quo);
        end
      end else begin
        if (d.ovf || d.quo > POS_MAX) begin
          clip = 1'b1;
          val  = {1'b0, {(PIX_W-1){1'b1}}};
        end else begin
          val = d.quo[PIX_W-1:0];
        end
      end
      sat_lane = {clip, val};
    end
  endfunction

  logic [PIX_W:0] su, sv;
  logic           last_dz;
  logic [PIX_W-1:0] pu_r, pv_r;
  logic           dz_r, clip_r;

  assign su      = sat_lane(divu_r[QBITS]);
  assign sv      = sat_lane(divv_r[QBITS]);
  assign last_dz = ctl_r[QBITS].dz;

  always_ff @(posedge clk) begin
    if (adv[NSTG-1]) begin
      pu_r   <= last_dz ? '0 : su[PIX_W-1:0];
      pv_r   <= last_dz ? '0 : sv[PIX_W-1:0];
      dz_r   <= last_dz;
      clip_r <= !last_dz && (su[PIX_W] || sv[PIX_W]);
    end
  end

  assign out_pixel_u    = pu_r;
  assign out_pixel_v    = pv_r;
  assign out_depth_zero = dz_r;
  assign out_clipped    = clip_r;

  // ---------------- checks ----------------
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_depth_zero |-> out_pixel_u == '0 && out_pixel_v == '0 && !out_clipped)
    else $error("zero depth result carries non-zero pixel or clip");

  a_clip_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |->
      out_pixel_u == 16'sh7fff || out_pixel_u == 16'sh8000 ||
      out_pixel_v == 16'sh7fff || out_pixel_v == 16'sh8000)
    else $error("clipped result without a saturated coordinate");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready && (&v_r))
    else $error("input held off while the pipeline has room");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_u) && $stable(out_clipped))
    else $error("stalled result changed");

endmodule
`default_nettype wire
